FILE: hw/rtl/ttt_pkg.sv
// ----------------------------------------------------------------------------
// Tag tracker table package
// Field widths, op codes and sequencer states shared by the tracker RTL.
// ----------------------------------------------------------------------------
package ttt_pkg;

    localparam int TAG_W      = 24;
    localparam int SEQ_W      = 8;
    localparam int RSSI_W     = 8;
    localparam int TIME_W     = 32;
    localparam int MISS_W     = 16;
    localparam int SLOT_OUT_W = 3;
    localparam int CNT_OUT_W  = 4;
    localparam int OP_W       = 2;

    localparam logic [TIME_W-1:0] STALE_RESET = 32'd10000;

    // request op codes
    typedef enum logic [OP_W-1:0] {
        OP_UPDATE = 2'd0,
        OP_PRUNE  = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    // sequencer states, one-hot
    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_DECIDE = 5'b00100,
        S_SUM    = 5'b01000,
        S_DIV    = 5'b10000
    } t_state;

    // handshake with the serial divider
    typedef struct packed {
        logic done;
    } t_div_stat;

endpackage

FILE: hw/rtl/ttt_div.sv
// ----------------------------------------------------------------------------
// Serial signed divider
// Restoring divide, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module ttt_div
    import ttt_pkg::*;
#(
    parameter int NUM_W = 12,
    parameter int DEN_W = 3
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [NUM_W-1:0] i_dividend,
    input  logic        [DEN_W-1:0] i_divisor,
    output t_div_stat               o_stat,
    output logic signed [NUM_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_num;
    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic             r_neg;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;
    logic [NUM_W-1:0] q_next;

    // one restoring step
    always_comb begin
        trial  = {r_rem, r_num[NUM_W-1]};
        diff   = trial - {1'b0, r_den};
        fits   = (trial >= {1'b0, r_den});
        q_next = {r_q[NUM_W-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            o_stat.done <= 1'b0;
        end else begin
            o_stat.done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
                r_num  <= NUM_W'(i_dividend[NUM_W-1] ? -i_dividend : i_dividend);
                r_neg  <= i_dividend[NUM_W-1];
                r_den  <= i_divisor;
                r_rem  <= '0;
                r_q    <= '0;
            end else if (r_busy) begin
                r_num <= {r_num[NUM_W-2:0], 1'b0};
                r_q   <= q_next;
                r_rem <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy      <= 1'b0;
                    o_stat.done <= 1'b1;
                    o_quotient  <= r_neg ? -$signed(q_next) : $signed(q_next);
                end
            end
        end
    end

endmodule

FILE: hw/rtl/tag_tracker_table.sv
// ----------------------------------------------------------------------------
// Tag tracker table
// Tracks radio tags by id: update with report, prune stale entries, and
// return the mean RSSI of a tag's recent reports.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays
// high until the result, which shows on the o_ result ports for exactly one
// cycle with o_done high and must be captured then. One slot-record memory
// port is walked once per request, one slot per cycle. A query that finds
// its tag with history then sums the stored samples of its RSSI ring and
// divides the sum by fill (the number of stored samples) in the serial
// divider. No clearing pass follows reset.
module tag_tracker_table
    import ttt_pkg::*;
#(
    parameter int TAG_SLOTS     = 8,
    parameter int HISTORY_DEPTH = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [TIME_W-1:0]         i_cfg_wdata,
    input  logic                      start,
    output logic                      busy,
    input  logic [OP_W-1:0]           i_op,
    input  logic [TAG_W-1:0]          i_tag_id,
    input  logic [SEQ_W-1:0]          i_seq,
    input  logic signed [RSSI_W-1:0]  i_rssi,
    input  logic [TIME_W-1:0]         i_now_ms,
    output logic                      o_done,
    output logic                      o_status,
    output logic [SLOT_OUT_W-1:0]     o_slot,
    output logic                      o_is_new,
    output logic                      o_duplicate,
    output logic [MISS_W-1:0]         o_missed_count,
    output logic signed [RSSI_W-1:0]  o_rssi_avg,
    output logic [CNT_OUT_W-1:0]      o_removed,
    output logic [CNT_OUT_W-1:0]      o_entry_count
);

    localparam int SW   = (TAG_SLOTS > 1) ? $clog2(TAG_SLOTS) : 1;
    localparam int CW   = $clog2(TAG_SLOTS + 1);
    localparam int PW   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int FW   = $clog2(HISTORY_DEPTH + 1);
    localparam int HN   = TAG_SLOTS * HISTORY_DEPTH;
    localparam int HW   = (HN > 1) ? $clog2(HN) : 1;
    localparam int SUMW = RSSI_W + $clog2(HISTORY_DEPTH);

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [SEQ_W-1:0]  seq;
        logic [TIME_W-1:0] seen;
        logic [MISS_W-1:0] missed;
        logic [PW-1:0]     pos;
        logic [FW-1:0]     fill;
    } t_entry;

    // state and storage
    t_state                   r_state, n_state;
    logic [TAG_SLOTS-1:0]     r_valid;
    logic [CW-1:0]            r_used;
    logic [TIME_W-1:0]        r_stale;
    t_entry                   r_mem [TAG_SLOTS];
    t_entry                   r_rd;
    logic signed [RSSI_W-1:0] r_hist [HN];
    logic signed [RSSI_W-1:0] r_hrd;

    // latched request
    t_op                      r_op;
    logic [TAG_W-1:0]         r_tag;
    logic [SEQ_W-1:0]         r_seq;
    logic signed [RSSI_W-1:0] r_rssi;
    logic [TIME_W-1:0]        r_now;

    // scan state
    logic [CW-1:0]            r_cidx;
    logic [SW-1:0]            r_pidx;
    logic                     r_pvalid;
    logic                     r_hit;
    logic [SW-1:0]            r_hit_idx;
    t_entry                   r_hrec;
    logic                     r_free;
    logic [SW-1:0]            r_free_idx;
    logic                     r_best_ok;
    logic [SW-1:0]            r_best;
    logic [TIME_W-1:0]        r_best_age;
    logic [CW-1:0]            r_removed;

    // averaging state
    logic [FW-1:0]            r_k;
    logic                     r_hpend;
    logic [HW-1:0]            r_hbase;
    logic signed [SUMW-1:0]   r_sum;
    logic                     r_div_go;
    t_div_stat                div_stat;
    logic signed [SUMW-1:0]   div_q;

    // combinational helpers
    logic              scan_v;
    logic [TIME_W-1:0] scan_age;
    logic              scan_stale;
    logic              scan_last;
    logic              sum_last;
    logic [SEQ_W-1:0]  gap;
    logic              dup;
    logic [MISS_W-1:0] miss_new;
    logic              alloc_ok;
    logic [SW-1:0]     alloc_idx;
    logic              mem_we;
    logic [SW-1:0]     mem_waddr;
    t_entry            mem_wdata;
    logic              hist_we;
    logic [HW-1:0]     hist_waddr;
    logic [HW-1:0]     hist_raddr;
    logic              set_valid;
    logic              used_inc;
    logic              go_sum;
    logic              res_status;
    logic [SW-1:0]     res_slot;
    logic              res_new;
    logic              res_dup;
    logic [MISS_W-1:0] res_missed;
    logic [CW-1:0]     n_used;

    assign busy = (r_state != S_IDLE);

    // per-slot evaluation during the scan
    always_comb begin
        scan_v     = r_valid[r_pidx];
        scan_age   = r_now - r_rd.seen;
        scan_stale = (scan_age >= r_stale);
        scan_last  = !r_pvalid && (r_cidx == CW'(TAG_SLOTS));
        sum_last   = !r_hpend && (r_k == r_hrec.fill);
        hist_raddr = r_hbase + HW'(r_k);
    end

    // decision on the scan result
    always_comb begin
        gap       = r_seq - r_hrec.seq;
        dup       = (gap == '0);
        miss_new  = (gap > SEQ_W'(1)) ? r_hrec.missed + MISS_W'(gap - SEQ_W'(1))
                                      : r_hrec.missed;
        alloc_ok  = r_free || (r_best_ok && (r_best_age >= r_stale));
        alloc_idx = r_free ? r_free_idx : r_best;

        mem_we     = 1'b0;
        mem_waddr  = r_hit_idx;
        mem_wdata  = r_hrec;
        hist_we    = 1'b0;
        hist_waddr = HW'(r_hit_idx) * HW'(HISTORY_DEPTH) + HW'(r_hrec.pos);
        set_valid  = 1'b0;
        used_inc   = 1'b0;
        go_sum     = 1'b0;
        res_status = 1'b0;
        res_slot   = '0;
        res_new    = 1'b0;
        res_dup    = 1'b0;
        res_missed = '0;

        if (r_state == S_DECIDE) begin
            unique case (r_op)
                OP_UPDATE: begin
                    if (r_hit) begin
                        // known tag: refresh; unless a duplicate, count gap and push sample
                        mem_we         = 1'b1;
                        mem_wdata.seen = r_now;
                        res_slot       = r_hit_idx;
                        res_dup        = dup;
                        res_missed     = r_hrec.missed;
                        if (!dup) begin
                            mem_wdata.seq    = r_seq;
                            mem_wdata.missed = miss_new;
                            mem_wdata.pos    = (r_hrec.pos == PW'(HISTORY_DEPTH - 1)) ?
                                               '0 : r_hrec.pos + 1'b1;
                            mem_wdata.fill   = (r_hrec.fill < FW'(HISTORY_DEPTH)) ?
                                               r_hrec.fill + 1'b1 : r_hrec.fill;
                            hist_we          = 1'b1;
                            res_missed       = miss_new;
                        end
                    end else if (alloc_ok) begin
                        // new entry in a free or evicted slot
                        mem_we           = 1'b1;
                        mem_waddr        = alloc_idx;
                        mem_wdata.tag    = r_tag;
                        mem_wdata.seq    = r_seq;
                        mem_wdata.seen   = r_now;
                        mem_wdata.missed = '0;
                        mem_wdata.pos    = PW'(1 % HISTORY_DEPTH);
                        mem_wdata.fill   = FW'(1);
                        hist_we          = 1'b1;
                        hist_waddr       = HW'(alloc_idx) * HW'(HISTORY_DEPTH);
                        set_valid        = 1'b1;
                        used_inc         = r_free;
                        res_slot         = alloc_idx;
                        res_new          = 1'b1;
                    end else begin
                        res_status = 1'b1;
                    end
                end
                OP_QUERY: begin
                    if (!r_hit) begin
                        res_status = 1'b1;
                    end else begin
                        res_slot = r_hit_idx;
                        go_sum   = (r_hrec.fill != '0);
                    end
                end
                OP_PRUNE, OP_NONE: begin
                end
                default: begin
                end
            endcase
        end
        n_used = r_used + CW'(used_inc);
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (start) n_state = S_SCAN;
            S_SCAN:   if (scan_last) n_state = S_DECIDE;
            S_DECIDE: n_state = go_sum ? S_SUM : S_IDLE;
            S_SUM:    if (sum_last) n_state = S_DIV;
            S_DIV:    if (div_stat.done) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // slot records and RSSI rings
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= r_mem[r_cidx[SW-1:0]];
        if (hist_we) begin
            r_hist[hist_waddr] <= r_rssi;
        end
        r_hrd <= r_hist[hist_raddr];
    end

    // control and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_used   <= '0;
            r_stale  <= STALE_RESET;
            o_done   <= 1'b0;
            r_div_go <= 1'b0;
            r_pvalid <= 1'b0;
            r_hpend  <= 1'b0;
        end else begin
            o_done   <= 1'b0;
            r_div_go <= 1'b0;
            r_state  <= n_state;
            if (i_cfg_we) begin
                r_stale <= i_cfg_wdata;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_op       <= t_op'(i_op);
                        r_tag      <= i_tag_id;
                        r_seq      <= i_seq;
                        r_rssi     <= i_rssi;
                        r_now      <= i_now_ms;
                        r_cidx     <= '0;
                        r_pvalid   <= 1'b0;
                        r_hit      <= 1'b0;
                        r_free     <= 1'b0;
                        r_best_ok  <= 1'b0;
                        r_best_age <= '0;
                        r_removed  <= '0;
                    end
                end
                S_SCAN: begin
                    // issue next slot read, evaluate the one returned
                    r_pidx   <= r_cidx[SW-1:0];
                    r_pvalid <= (r_cidx != CW'(TAG_SLOTS));
                    if (r_cidx != CW'(TAG_SLOTS)) begin
                        r_cidx <= r_cidx + 1'b1;
                    end
                    if (r_pvalid) begin
                        if (scan_v && (r_rd.tag == r_tag) && !r_hit) begin
                            r_hit     <= 1'b1;
                            r_hit_idx <= r_pidx;
                            r_hrec    <= r_rd;
                        end
                        if (r_op == OP_UPDATE) begin
                            if (!scan_v && !r_free) begin
                                r_free     <= 1'b1;
                                r_free_idx <= r_pidx;
                            end
                            if (scan_age > r_best_age) begin
                                r_best_age <= scan_age;
                                r_best     <= r_pidx;
                                r_best_ok  <= 1'b1;
                            end
                        end
                        if ((r_op == OP_PRUNE) && scan_v && scan_stale) begin
                            r_valid[r_pidx] <= 1'b0;
                            r_removed       <= r_removed + 1'b1;
                            if (r_used != '0) begin
                                r_used <= r_used - 1'b1;
                            end
                        end
                    end
                end
                S_DECIDE: begin
                    if (set_valid) begin
                        r_valid[alloc_idx] <= 1'b1;
                    end
                    r_used <= n_used;
                    if (go_sum) begin
                        r_k     <= '0;
                        r_hpend <= 1'b0;
                        r_sum   <= '0;
                        r_hbase <= HW'(r_hit_idx) * HW'(HISTORY_DEPTH);
                    end else begin
                        o_done         <= 1'b1;
                        o_status       <= res_status;
                        o_slot         <= SLOT_OUT_W'(res_slot);
                        o_is_new       <= res_new;
                        o_duplicate    <= res_dup;
                        o_missed_count <= res_missed;
                        o_rssi_avg     <= '0;
                        o_removed      <= (r_op == OP_PRUNE) ? CNT_OUT_W'(r_removed) : '0;
                        o_entry_count  <= CNT_OUT_W'(n_used);
                    end
                end
                S_SUM: begin
                    // accumulate the stored samples in ring index order
                    r_hpend <= (r_k != r_hrec.fill);
                    if (r_k != r_hrec.fill) begin
                        r_k <= r_k + 1'b1;
                    end
                    if (r_hpend) begin
                        r_sum <= r_sum + SUMW'(r_hrd);
                    end
                    if (sum_last) begin
                        r_div_go <= 1'b1;
                    end
                end
                S_DIV: begin
                    if (div_stat.done) begin
                        o_done         <= 1'b1;
                        o_status       <= 1'b0;
                        o_slot         <= SLOT_OUT_W'(r_hit_idx);
                        o_is_new       <= 1'b0;
                        o_duplicate    <= 1'b0;
                        o_missed_count <= '0;
                        o_rssi_avg     <= div_q[RSSI_W-1:0];
                        o_removed      <= '0;
                        o_entry_count  <= CNT_OUT_W'(r_used);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // mean of the stored samples
    ttt_div #(
        .NUM_W (SUMW),
        .DEN_W (FW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_go),
        .i_dividend (r_sum),
        .i_divisor  (r_hrec.fill),
        .o_stat     (div_stat),
        .o_quotient (div_q)
    );

`ifndef SYNTHESIS
    // result strobe only once the sequencer is back at rest
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // entry count tracks the valid bits
    a_used_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used == $countones(r_valid))
        else $error("entry count out of step with valid bits");

    // an accepted request starts the slot scan
    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == S_SCAN))
        else $error("accepted request did not start scan");

    // the divider runs only for a query that found its tag
    a_div_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_go |-> ((r_op == OP_QUERY) && r_hit))
        else $error("divider started outside a query hit");
`endif

endmodule
